@@ rtl/vos_pkg.sv @@
package vos_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CFG_INDEX_W = 1;

	localparam logic OP_RENDER = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] CFG_FLIP_SCREEN = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CLOUD_POSITION = 1'd1;

	localparam logic [2:0] PEN_BLUE = 3'd2;
	localparam logic [2:0] PEN_CYAN = 3'd6;
	localparam logic [2:0] PEN_WHITE = 3'd7;

	typedef struct packed {
		logic       flip_screen;
		logic [7:0] cloud_position;
	} vos_cfg_t;

	typedef struct packed {
		logic [7:0] row;
		logic [4:0] col_hi;
		logic [7:0] data;
		logic [2:0] fore;
		logic       back_cyan;
		logic       cloud_on;
		logic [7:0] cloud_lo;
		logic [7:0] cloud_hi;
	} vos_entry_t;

	typedef struct packed {
		logic       valid;
		vos_entry_t entry;
	} vos_slot_t;

endpackage

@@ rtl/vos_in_if.sv @@
interface vos_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [12:0] byte_offset;
	logic [7:0] video_byte;
	logic [7:0] color_ram_byte;
	logic [7:0] map_prom_byte;
	logic [7:0] cloud_load_address;
	logic [7:0] cloud_load_data;

	modport source(output valid, opcode, byte_offset, video_byte, color_ram_byte,
		map_prom_byte, cloud_load_address, cloud_load_data, input ready);
	modport sink(input valid, opcode, byte_offset, video_byte, color_ram_byte,
		map_prom_byte, cloud_load_address, cloud_load_data, output ready);
endinterface

@@ rtl/vos_out_if.sv @@
interface vos_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] screen_row;
	logic [8:0] screen_column;
	logic [2:0] pen_index;
	logic       red_on;
	logic       green_on;
	logic       blue_on;
	logic       last_pixel;

	modport source(output valid, screen_row, screen_column, pen_index, red_on,
		green_on, blue_on, last_pixel, input ready);
	modport sink(input valid, screen_row, screen_column, pen_index, red_on,
		green_on, blue_on, last_pixel, output ready);
endinterface

@@ rtl/vos_cfg_if.sv @@
interface vos_cfg_if;
	logic       valid;
	logic       ready;
	logic [0:0] index;
	logic [7:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/vos_front.sv @@
module vos_front #(
	parameter int FIRST_VISIBLE_LINE = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	vos_in_if.sink            item,
	input  vos_pkg::vos_cfg_t cfg,
	input  logic              push_ready,
	output vos_pkg::vos_slot_t push
);
	import vos_pkg::*;

	localparam logic [7:0] FIRST_LINE = FIRST_VISIBLE_LINE[7:0];

	logic [7:0] cloud_rom [256];
	logic       valid_s1;
	logic [7:0] row_s1;
	logic [4:0] col_hi_s1;
	logic [7:0] data_s1;
	logic [2:0] fore_s1;
	logic       back_cyan_s1;
	logic       cloud_on_s1;
	logic [7:0] cloud_lo_s1;
	logic [7:0] cloud_hi_s1;

	logic       accept;
	logic       visible;
	logic [7:0] y;
	logic [7:0] cloud_y;
	logic [7:0] addr_lo;
	logic [7:0] addr_hi;

	assign y = item.byte_offset[12:5];
	assign cloud_y = y - cfg.cloud_position;
	assign visible = !(y < FIRST_LINE);
	assign addr_lo = {~cloud_y[5:0], item.byte_offset[0], 1'b0};
	assign addr_hi = {~cloud_y[5:0], item.byte_offset[0], 1'b1};

	assign item.ready = !valid_s1 || push_ready;
	assign accept = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (item.opcode == OP_RENDER) && visible;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1 <= y - FIRST_LINE;
			col_hi_s1 <= item.byte_offset[4:0];
			data_s1 <= item.video_byte;
			fore_s1 <= ~item.color_ram_byte[2:0];
			back_cyan_s1 <= item.map_prom_byte[0];
			cloud_on_s1 <= !item.map_prom_byte[3] && (cloud_y[7:6] == 2'b00);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.opcode == OP_LOAD) begin
			cloud_rom[item.cloud_load_address] <= item.cloud_load_data;
		end
		if (accept) begin
			cloud_lo_s1 <= cloud_rom[addr_lo];
			cloud_hi_s1 <= cloud_rom[addr_hi];
		end
	end

	always_comb begin
		push.valid = valid_s1;
		push.entry.row = row_s1;
		push.entry.col_hi = col_hi_s1;
		push.entry.data = data_s1;
		push.entry.fore = fore_s1;
		push.entry.back_cyan = back_cyan_s1;
		push.entry.cloud_on = cloud_on_s1;
		push.entry.cloud_lo = cloud_lo_s1;
		push.entry.cloud_hi = cloud_hi_s1;
	end
endmodule

@@ rtl/vos_queue.sv @@
module vos_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  vos_pkg::vos_slot_t push,
	output logic               push_ready,
	output vos_pkg::vos_slot_t head,
	input  logic               pop
);
	import vos_pkg::*;

	vos_entry_t               slots [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [QUEUE_PTR_W:0]     count_q;
	logic                     do_push;
	logic                     do_pop;

	assign push_ready = (count_q != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign do_push = push.valid && push_ready;
	assign do_pop = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.entry = slots[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots[wr_ptr_q] <= push.entry;
		end
	end
endmodule

@@ rtl/vos_back.sv @@
module vos_back #(
	parameter int VISIBLE_LINE_END = 224,
	parameter int LINE_PIXELS = 260
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vos_pkg::vos_cfg_t  cfg,
	input  vos_pkg::vos_slot_t head,
	output logic               pop,
	vos_out_if.source          pixel
);
	import vos_pkg::*;

	localparam logic [7:0] ROW_TOP = 8'(VISIBLE_LINE_END - 1);
	localparam logic [8:0] COL_TOP = 9'(LINE_PIXELS - 1);

	vos_entry_t cur_q;
	logic       cur_valid_q;
	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] row_q;
	logic [8:0] col_q;
	logic [2:0] pen_q;
	logic       last_q;

	logic       out_load;
	logic       done;
	logic [7:0] x;
	logic [7:0] cloud_byte;
	logic       cloud_bit;
	logic [2:0] pen;

	assign out_load = cur_valid_q && (!out_valid_q || pixel.ready);
	assign done = out_load && (idx_q == 3'd7);
	assign pop = !cur_valid_q || done;

	assign x = {cur_q.col_hi, idx_q};
	assign cloud_byte = idx_q[2] ? cur_q.cloud_hi : cur_q.cloud_lo;
	assign cloud_bit = cloud_byte[~idx_q[1:0]];

	always_comb begin
		if (cur_q.data[idx_q]) begin
			pen = cur_q.fore;
		end else if (cur_q.cloud_on && cloud_bit) begin
			pen = PEN_WHITE;
		end else if (cur_q.back_cyan) begin
			pen = PEN_CYAN;
		end else begin
			pen = PEN_BLUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= head.valid;
				idx_q <= '0;
			end else if (out_load) begin
				idx_q <= idx_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pixel.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.entry;
		end
		if (out_load) begin
			row_q <= cfg.flip_screen ? ROW_TOP - cur_q.row : cur_q.row;
			col_q <= cfg.flip_screen ? COL_TOP - {1'b0, x} : {1'b0, x};
			pen_q <= pen;
			last_q <= (idx_q == 3'd7);
		end
	end

	assign pixel.valid = out_valid_q;
	assign pixel.screen_row = row_q;
	assign pixel.screen_column = col_q;
	assign pixel.pen_index = pen_q;
	assign pixel.red_on = pen_q[0];
	assign pixel.green_on = pen_q[2];
	assign pixel.blue_on = pen_q[1];
	assign pixel.last_pixel = last_q;
endmodule

@@ rtl/bitmap_video_cloud_overlay_shifter.sv @@
// Bitmap video shifter with a cloud overlay band.
// The item channel takes one transfer per video byte (opcode render) or per
// cloud ROM byte (opcode load). A render transfer on a visible line gives
// eight pixel transfers on the pixel channel, video bit 0 first, the eighth
// marked by last_pixel. Loads and vertical blank lines give no pixels.
// The config channel writes flip_screen (index 0) and cloud_position
// (index 1); it is always ready. The user must write it only while the
// block is idle; the block itself does not enforce this.
// With the queue and the back idle, an item passes the front register, a
// queue slot, the back's current-byte register and the output register.
// Pixels stream at one per clock while the pixel receiver is ready, one
// for each pixel of a byte; loads and blank lines never enter the queue.
// A four-entry queue between the classifying front and the pixel back lets
// the front keep taking items while the back shifts out earlier bytes.
// When the pixel receiver stalls, the output register holds its pixel, the
// queue fills and the item channel then drops ready.
// Reset clears the valid flags, queue and config; the cloud ROM content is
// undefined until loaded.
module bitmap_video_cloud_overlay_shifter #(
	parameter int FIRST_VISIBLE_LINE = 32,
	parameter int VISIBLE_LINE_END = 224,
	parameter int LINE_PIXELS = 260
) (
	input  logic      clk,
	input  logic      arst_n,
	vos_in_if.sink    item,
	vos_cfg_if.sink   cfg,
	vos_out_if.source pixel
);
	import vos_pkg::*;

	vos_cfg_t  cfg_q;
	vos_slot_t push;
	vos_slot_t head;
	logic      push_ready;
	logic      pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flip_screen <= 1'b0;
			cfg_q.cloud_position <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_FLIP_SCREEN: cfg_q.flip_screen <= cfg.data[0];
				CFG_CLOUD_POSITION: cfg_q.cloud_position <= cfg.data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	vos_front #(
		.FIRST_VISIBLE_LINE(FIRST_VISIBLE_LINE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cfg(cfg_q),
		.push_ready(push_ready),
		.push(push)
	);

	vos_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_ready(push_ready),
		.head(head),
		.pop(pop)
	);

	vos_back #(
		.VISIBLE_LINE_END(VISIBLE_LINE_END),
		.LINE_PIXELS(LINE_PIXELS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head(head),
		.pop(pop),
		.pixel(pixel)
	);
endmodule

@@ bench/vos_pixel_checker.sv @@
`timescale 1ns / 100ps

module vos_pixel_checker (
	input  logic clk,
	input  logic arst_n,
	vos_in_if    item,
	vos_cfg_if   cfg,
	vos_out_if   pixel,
	output int   fail_count,
	output int   pixels_pending,
	output int   pixels_seen
);
	import vos_pkg::*;

	localparam int FIRST_LINE = 32;
	localparam int LINE_END = 224;
	localparam int LINE_PIXELS = 260;

	typedef struct packed {
		logic [7:0] row;
		logic [8:0] col;
		logic [2:0] pen;
		logic       red;
		logic       green;
		logic       blue;
		logic       last;
	} pixel_t;

	pixel_t     expected_pixels[$];
	logic [7:0] cloud_copy[256];
	logic       flip;
	logic [7:0] cloud_pos;
	int         mismatches = 0;
	int         seen = 0;
	int         waiting = 0;

	assign fail_count = mismatches;
	assign pixels_pending = waiting;
	assign pixels_seen = seen;

	// Works out the eight pixels that one video byte on a visible line produces.
	task automatic predict_byte(input logic [12:0] offs, input logic [7:0] bits,
		input logic [7:0] color, input logic [7:0] prom);
		logic [7:0] y;
		logic [7:0] x;
		logic [7:0] row;
		logic [7:0] cy;
		logic [7:0] rom_byte;
		logic [2:0] fore;
		logic [2:0] back;
		logic       band;
		pixel_t     p;
		int         i;
		y = offs[12:5];
		if (y >= FIRST_LINE) begin
			row = y - 8'(FIRST_LINE);
			fore = ~color[2:0];
			back = prom[0] ? PEN_CYAN : PEN_BLUE;
			cy = y - cloud_pos;
			band = !prom[3] && (cy < 8'd64);
			for (i = 0; i < 8; i++) begin
				x = {offs[4:0], 3'b000} + 8'(i);
				if (bits[i]) begin
					p.pen = fore;
				end else if (band) begin
					rom_byte = cloud_copy[{~cy[5:0], x[3:2]}];
					p.pen = rom_byte[3 - x[1:0]] ? PEN_WHITE : back;
				end else begin
					p.pen = back;
				end
				p.row = flip ? 8'(LINE_END - 1 - int'(row)) : row;
				p.col = flip ? 9'(LINE_PIXELS - 1 - int'(x)) : 9'(x);
				p.red = p.pen[0];
				p.green = p.pen[2];
				p.blue = p.pen[1];
				p.last = (i == 7);
				expected_pixels.push_back(p);
			end
		end
	endtask

	function automatic void check_field(input string name, input logic [8:0] want,
		input logic [8:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			expected_pixels.delete();
			foreach (cloud_copy[k]) cloud_copy[k] = 8'h00;
			flip = 1'b0;
			cloud_pos = 8'h00;
			waiting = 0;
		end else begin
			if (pixel.valid && pixel.ready) begin
				seen++;
				if (expected_pixels.size() == 0) begin
					$error("unexpected pixel transfer: row %0d column %0d pen %0d",
						pixel.screen_row, pixel.screen_column, pixel.pen_index);
					mismatches++;
				end else begin
					want = expected_pixels.pop_front();
					check_field("screen_row", 9'(want.row), 9'(pixel.screen_row));
					check_field("screen_column", want.col, pixel.screen_column);
					check_field("pen_index", 9'(want.pen), 9'(pixel.pen_index));
					check_field("red_on", 9'(want.red), 9'(pixel.red_on));
					check_field("green_on", 9'(want.green), 9'(pixel.green_on));
					check_field("blue_on", 9'(want.blue), 9'(pixel.blue_on));
					check_field("last_pixel", 9'(want.last), 9'(pixel.last_pixel));
				end
			end
			if (item.valid && item.ready) begin
				if (item.opcode == OP_LOAD) begin
					cloud_copy[item.cloud_load_address] = item.cloud_load_data;
				end else begin
					predict_byte(item.byte_offset, item.video_byte, item.color_ram_byte,
						item.map_prom_byte);
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_FLIP_SCREEN) begin
					flip = cfg.data[0];
				end else if (cfg.index == CFG_CLOUD_POSITION) begin
					cloud_pos = cfg.data;
				end
			end
			waiting = expected_pixels.size();
		end
	end

endmodule

@@ bench/tb_bitmap_video_cloud_overlay_shifter.sv @@
`timescale 1ns / 100ps

module tb_bitmap_video_cloud_overlay_shifter;
	import vos_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_took = 1'b0;
	logic cfg_took = 1'b0;
	logic calm = 1'b0;
	logic written[256];
	logic [7:0] cur_pos = 8'h00;
	int quiet_cycles = 0;
	int n_items = 0;
	int n_loads = 0;
	int n_settings = 1;
	int fail_count;
	int pixels_pending;
	int pixels_seen;

	vos_in_if item_ch();
	vos_cfg_if cfg_ch();
	vos_out_if pixel_ch();

	bitmap_video_cloud_overlay_shifter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.cfg(cfg_ch),
		.pixel(pixel_ch)
	);

	vos_pixel_checker pixel_check (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.cfg(cfg_ch),
		.pixel(pixel_ch),
		.fail_count(fail_count),
		.pixels_pending(pixels_pending),
		.pixels_seen(pixels_seen)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		item_took <= item_ch.valid && item_ch.ready;
		cfg_took <= cfg_ch.valid && cfg_ch.ready;
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
			(pixel_ch.valid && pixel_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("No transfer for %0d cycles, %0d pixels still expected.",
				QUIET_LIMIT, pixels_pending);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		pixel_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			pixel_ch.ready <= calm || ($urandom_range(0, 99) >= 15);
		end
	end

	task automatic send_item(input logic op, input logic [12:0] offs, input logic [7:0] bits,
		input logic [7:0] color, input logic [7:0] prom, input logic [7:0] addr,
		input logic [7:0] data);
		if (!calm) begin
			while ($urandom_range(0, 99) < 15) begin
				item_ch.valid <= 1'b0;
				@(negedge clk);
			end
		end
		item_ch.valid <= 1'b1;
		item_ch.opcode <= op;
		item_ch.byte_offset <= offs;
		item_ch.video_byte <= bits;
		item_ch.color_ram_byte <= color;
		item_ch.map_prom_byte <= prom;
		item_ch.cloud_load_address <= addr;
		item_ch.cloud_load_data <= data;
		do @(negedge clk); while (!item_took);
		n_items++;
	endtask

	task automatic load_cloud(input logic [7:0] addr, input logic [7:0] data);
		send_item(OP_LOAD, 13'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			addr, data);
		written[addr] = 1'b1;
		n_loads++;
	endtask

	// A render inside the cloud band reads two cloud ROM bytes; both must hold
	// loaded data before the render goes out.
	task automatic cover_cloud_reads(input logic [12:0] offs, input logic [7:0] prom);
		logic [7:0] y;
		logic [7:0] cy;
		logic [7:0] addr;
		int k;
		y = offs[12:5];
		cy = y - cur_pos;
		if (y >= 8'd32 && !prom[3] && cy < 8'd64) begin
			for (k = 0; k < 2; k++) begin
				addr = {~cy[5:0], offs[0], 1'(k)};
				if (!written[addr]) load_cloud(addr, 8'($urandom));
			end
		end
	endtask

	task automatic render_byte(input logic [12:0] offs, input logic [7:0] bits,
		input logic [7:0] color, input logic [7:0] prom);
		cover_cloud_reads(offs, prom);
		send_item(OP_RENDER, offs, bits, color, prom, 8'($urandom), 8'($urandom));
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [7:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(negedge clk); while (!cfg_took);
	endtask

	// Settings change only with the block drained; loads and blank lines may
	// still be in flight, so the task also waits for them to pass first.
	task automatic apply_setting(input logic flip, input logic [7:0] pos);
		item_ch.valid <= 1'b0;
		while (pixels_pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		write_reg(CFG_FLIP_SCREEN, {7'd0, flip});
		write_reg(CFG_CLOUD_POSITION, pos);
		cfg_ch.valid <= 1'b0;
		cur_pos = pos;
		n_settings++;
	endtask

	initial begin
		logic [7:0] y;
		logic [12:0] offs;
		logic [7:0] bits;
		int n;
		foreach (written[k]) written[k] = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.opcode = OP_RENDER;
		item_ch.byte_offset = '0;
		item_ch.video_byte = '0;
		item_ch.color_ram_byte = '0;
		item_ch.map_prom_byte = '0;
		item_ch.cloud_load_address = '0;
		item_ch.cloud_load_data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_FLIP_SCREEN;
		cfg_ch.data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		load_cloud(8'd0, 8'hff);
		load_cloud(8'd255, 8'h00);
		render_byte(13'd0, 8'hff, 8'h00, 8'h00);
		render_byte(13'd1023, 8'h00, 8'hff, 8'hff);
		render_byte(13'd1024, 8'h00, 8'hff, 8'h00);
		render_byte(13'd1055, 8'hff, 8'h00, 8'h01);
		render_byte(13'd2047, 8'h00, 8'h5a, 8'h01);
		render_byte(13'd2048, 8'h00, 8'ha5, 8'h01);
		render_byte(13'd3200, 8'haa, 8'h33, 8'h08);
		render_byte(13'd8191, 8'h55, 8'hf8, 8'hff);
		apply_setting(1'b1, 8'd255);
		render_byte(13'd8191, 8'h00, 8'h00, 8'h00);
		render_byte(13'd1024, 8'h81, 8'h06, 8'h00);
		render_byte(13'd2000, 8'h00, 8'h00, 8'h09);
		apply_setting(1'b0, 8'd40);
		render_byte(13'd1280, 8'h00, 8'h01, 8'h00);
		render_byte(13'd3295, 8'h00, 8'h02, 8'h00);
		render_byte(13'd3296, 8'h00, 8'h04, 8'h01);

		for (n = 0; n_items < RANDOM_ITEMS; n++) begin
			calm = (n >= 90 && n < 150);
			case (n)
				0: begin
					apply_setting(1'b1, 8'd0);
				end
				60: begin
					apply_setting(1'b0, 8'd255);
				end
				120: begin
					apply_setting(1'b1, 8'($urandom));
				end
				180: begin
					apply_setting(1'b0, 8'($urandom));
				end
				default: begin
				end
			endcase
			if ($urandom_range(0, 99) < 12) begin
				load_cloud(8'($urandom), ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
			end else begin
				if ($urandom_range(0, 9) == 0) y = 8'($urandom_range(0, 31));
				else if ($urandom_range(0, 1) == 1) y = cur_pos + 8'($urandom_range(0, 63));
				else y = 8'($urandom_range(32, 255));
				offs = {y, 5'($urandom)};
				bits = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom);
				render_byte(offs, bits, 8'($urandom), 8'($urandom));
			end
		end

		calm = 1'b0;
		item_ch.valid <= 1'b0;
		while (pixels_pending != 0) @(negedge clk);
		repeat (16) @(negedge clk);
		$display("Run covered %0d item transfers (%0d cloud ROM loads) under %0d settings.",
			n_items, n_loads, n_settings);
		$display("Pixels checked: %0d, mismatches: %0d.", pixels_seen, fail_count);
		if (fail_count == 0 && pixels_pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
